// File: hw/rtl/sit4_pkg.sv
// ----------------------------------------------------------------------------
// sit4_pkg: shared types and constants of the skin influence top-4 selector
// Field widths, stream packing offsets, operation codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sit4_pkg;

	localparam int VID_W     = 12;
	localparam int BONE_IN_W = 10;
	localparam int BONE_W    = 8;
	localparam int WEIGHT_W  = 17;
	localparam int COUNT_W   = 13;
	localparam int ENTRY_W   = WEIGHT_W + BONE_W;  // weight low, bone high
	localparam int REPORTED  = 4;
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = 17;
	localparam int STEP_W    = 5;

	// input stream packing
	localparam int IN_DATA_W  = 40;
	localparam int VID_LSB    = 0;
	localparam int BONE_LSB   = VID_LSB + VID_W;
	localparam int WEIGHT_LSB = BONE_LSB + BONE_IN_W;

	// output stream packing
	localparam int OUT_DATA_W   = 112;
	localparam int OUT_BONE_LSB = VID_W;
	localparam int OUT_NORM_LSB = OUT_BONE_LSB + REPORTED * BONE_W;

	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'h10000;
	localparam logic [COUNT_W-1:0]  COUNT_RESET = 13'd4096;
	localparam logic [STEP_W-1:0]   LAST_STEP   = STEP_W'(QUO_W - 1);

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic accept;    // take an input transfer, launch the RAM read
		logic clr_step;  // write one zero row of the clearing pass
		logic look;      // RAM row is valid: update or fetch and clear
		logic div_step;  // one quotient bit on every lane
		logic out_load;  // move the finished result into the output register
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/sit4_ram.sv
// ----------------------------------------------------------------------------
// sit4_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sit4_ram #(
	parameter int WIDTH = 100,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/sit4_ctrl.sv
// ----------------------------------------------------------------------------
// sit4_ctrl: sequencing controller
// Clearing pass, accept, row update or fetch, divide, result handoff.
// ----------------------------------------------------------------------------
module sit4_ctrl
	import sit4_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = st.is_read ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// an add finishes with its row update and never enters the divider
	a_add_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) && !st.is_read |=> (state_q == ST_IDLE))
		else $error("add item did not return to idle after row update");
`endif

endmodule

// File: hw/rtl/sit4_dpath.sv
// ----------------------------------------------------------------------------
// sit4_dpath: influence store, slot selection and normalizing divider
// Per-vertex rows in RAM, weakest-slot replacement, four restoring divider
// lanes and the output register.
// ----------------------------------------------------------------------------
module sit4_dpath
	import sit4_pkg::*;
#(
	parameter int VERTICES  = 4096,
	parameter int MAX_BONES = 256,
	parameter int SLOTS     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic                  s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  cfg_valid,
	input  logic [COUNT_W-1:0]    cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	localparam int ADDR_W    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int ROW_W     = SLOTS * ENTRY_W;
	localparam int TOT_W     = WEIGHT_W + $clog2(SLOTS);
	localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EXT_SLOTS = (SLOTS > REPORTED) ? SLOTS : REPORTED;
	localparam int EXT_W     = EXT_SLOTS * ENTRY_W;
	localparam logic [16:0]       VERT_LIM = 17'(VERTICES);
	localparam logic [10:0]       BONE_LIM = 11'(MAX_BONES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTICES - 1);

	// input decode
	logic [VID_W-1:0]     in_vid;
	logic [BONE_IN_W-1:0] in_bone;
	logic [WEIGHT_W-1:0]  in_w;
	op_t                  in_op;
	logic                 in_present;
	logic                 in_keep;

	// item registers
	op_t                 op_q;
	logic [VID_W-1:0]    vid_q;
	logic [BONE_W-1:0]   bone_q;
	logic [WEIGHT_W-1:0] w_q;
	logic                keep_q;
	logic                present_q;

	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// RAM
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;

	// row evaluation
	logic [ROW_W-1:0]    row;
	logic [EXT_W-1:0]    row_ext;
	logic [ROW_W-1:0]    upd_row;
	logic [WEIGHT_W-1:0] min_w;
	logic [SIDX_W-1:0]   min_idx;
	logic [TOT_W-1:0]    total;
	logic                do_add;

	// divider lanes
	logic [TOT_W-1:0]    total_q;
	logic                zero_q;
	logic [STEP_W-1:0]   step_q;
	logic [TOT_W-1:0]    rem_q  [REPORTED];
	logic [QUO_W-1:0]    quo_q  [REPORTED];
	logic [BONE_W-1:0]   obone_q[REPORTED];
	logic [TOT_W-1:0]    rem_d  [REPORTED];
	logic [QUO_W-1:0]    quo_d  [REPORTED];

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic [OUT_DATA_W-1:0] out_word;

	assign in_vid     = s_tdata[VID_LSB +: VID_W];
	assign in_bone    = s_tdata[BONE_LSB +: BONE_IN_W];
	assign in_w       = s_tdata[WEIGHT_LSB +: WEIGHT_W];
	assign in_op      = op_t'(s_tuser);
	assign in_present = 17'(in_vid) < VERT_LIM;
	assign in_keep    = (in_op == OP_ADD) && in_present && (COUNT_W'(in_vid) < count_q)
		&& (11'(in_bone) < BONE_LIM);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= in_op;
			vid_q     <= in_vid;
			bone_q    <= in_bone[BONE_W-1:0];
			w_q       <= in_w;
			keep_q    <= in_keep;
			present_q <= in_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= COUNT_RESET;
			clr_addr_q <= '0;
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// row of the addressed vertex; an absent vertex reads as empty
	always_comb begin
		row     = present_q ? ram_rdata : '0;
		row_ext = EXT_W'(row);
		min_w   = row[WEIGHT_W-1:0];
		min_idx = '0;
		total   = '0;
		for (int s = 1; s < SLOTS; s++) begin
			if (row[s*ENTRY_W +: WEIGHT_W] < min_w) begin
				min_w   = row[s*ENTRY_W +: WEIGHT_W];
				min_idx = SIDX_W'(s);
			end
		end
		upd_row = row;
		for (int s = 0; s < SLOTS; s++) begin
			total = total + TOT_W'(row[s*ENTRY_W +: WEIGHT_W]);
			if (SIDX_W'(s) == min_idx) begin
				upd_row[s*ENTRY_W +: ENTRY_W] = {bone_q, w_q};
			end
		end
		do_add = keep_q && (w_q > min_w);
	end

	assign ram_we = cmd.clr_step
		|| (cmd.look && (((op_q == OP_ADD) && do_add) || ((op_q == OP_READ) && present_q)));
	assign ram_waddr = cmd.clr_step ? clr_addr_q : ADDR_W'(vid_q);
	assign ram_wdata = (cmd.look && (op_q == OP_ADD)) ? upd_row : '0;

	sit4_ram #(
		.WIDTH (ROW_W),
		.DEPTH (VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (ADDR_W'(in_vid)),
		.rdata (ram_rdata)
	);

	// restoring division, one quotient bit per lane and cycle; the quotient
	// register starts out holding the remaining dividend bits
	always_comb begin
		logic [TOT_W:0] trial;
		logic           ge;
		for (int r = 0; r < REPORTED; r++) begin
			trial    = {rem_q[r], quo_q[r][QUO_W-1]};
			ge       = trial >= {1'b0, total_q};
			rem_d[r] = ge ? TOT_W'(trial - {1'b0, total_q}) : TOT_W'(trial);
			quo_d[r] = {quo_q[r][QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			total_q <= total;
			zero_q  <= (total == '0);
			for (int r = 0; r < REPORTED; r++) begin
				rem_q[r]   <= TOT_W'(row_ext[r*ENTRY_W+1 +: WEIGHT_W-1]);
				quo_q[r]   <= {row_ext[r*ENTRY_W], FRAC_W'(0)};
				obone_q[r] <= row_ext[r*ENTRY_W+WEIGHT_W +: BONE_W];
			end
		end else if (cmd.div_step) begin
			for (int r = 0; r < REPORTED; r++) begin
				rem_q[r] <= rem_d[r];
				quo_q[r] <= quo_d[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.look) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// result word; a zero total binds everything to bone 0 at full weight
	always_comb begin
		out_word = '0;
		out_word[0 +: VID_W] = vid_q;
		for (int r = 0; r < REPORTED; r++) begin
			if (zero_q) begin
				out_word[OUT_NORM_LSB + r*WEIGHT_W +: WEIGHT_W] =
					(r == 0) ? FULL_WEIGHT : '0;
			end else begin
				out_word[OUT_BONE_LSB + r*BONE_W +: BONE_W]     = obone_q[r];
				out_word[OUT_NORM_LSB + r*WEIGHT_W +: WEIGHT_W] = quo_q[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= out_word;
			m_tuser_q <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign st.clr_last = (clr_addr_q == LAST_ADDR);
	assign st.is_read  = (op_q == OP_READ);
	assign st.div_last = (step_q == LAST_STEP);
	assign st.out_free = !m_tvalid_q || m_tready;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an untaken result");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && cmd.look && (op_q == OP_READ) |-> (ram_wdata == '0))
		else $error("read did not clear the vertex row");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !zero_q |-> (quo_q[0] <= FULL_WEIGHT))
		else $error("normalized weight above full scale");
`endif

endmodule

// File: hw/rtl/skin_influence_top4_select.sv
// ----------------------------------------------------------------------------
// skin_influence_top4_select: per-vertex top-4 bone influence selection
// Keeps the strongest bone influences of each vertex and reports them
// normalized to a sum of 1.0 (Q1.16) on readout.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the influence RAM, one
// vertex row per cycle, all VERTICES rows (4096 by default), with s_tready
// low; configuration writes are taken throughout. For an add transfer the
// accept cycle launches the RAM read of the vertex row, the next cycle picks
// the weakest slot (lowest index on ties) and, if the new weight exceeds it,
// writes the row back through the single RAM write port; each add is done
// before the next transfer is accepted. A read transfer fetches and clears
// the row, runs a restoring division of 17 steps, one quotient bit per cycle
// on four parallel lanes, and hands the result to the output register. The
// output register decouples the two sides: new items are accepted while a
// result waits, and only a read that completes while the previous result is
// still untaken holds in place. Adds for vertices at or above vertex_count
// or VERTICES, or with a bone at or above MAX_BONES, are dropped without a
// result. A zero-sum vertex reports bone 0 at full weight with m_tuser set.
// ----------------------------------------------------------------------------
module skin_influence_top4_select
	import sit4_pkg::*;
#(
	parameter int VERTICES  = 4096,
	parameter int MAX_BONES = 256,
	parameter int SLOTS     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // vertex_id, bone_index, weight, zero pad
	input  logic                  s_tuser,   // operation: 0 add, 1 read and clear
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_vertex, bone_a..bone_d, norm_a..norm_d
	output logic                  m_tuser,   // unweighted
	// vertex_count register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data
);

	cmd_t    cmd;
	status_t st;

	// register writes are always taken, so the port never pushes back
	assign cfg_ready = 1'b1;

	sit4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sit4_dpath #(
		.VERTICES  (VERTICES),
		.MAX_BONES (MAX_BONES),
		.SLOTS     (SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
